@@ rtl/clnib_pkg.sv @@
// Shared types and constants for the character LCD nibble interface.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package clnib_pkg;

	localparam int MAX_DIGITS_DEF  = 5;
	localparam int DIGIT_CAP       = 6;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int INIT_STROBES    = 14;

	typedef enum logic [2:0] {
		ACT_INIT   = 3'd0,
		ACT_CMD    = 3'd1,
		ACT_DATA   = 3'd2,
		ACT_CURSOR = 3'd3,
		ACT_PRINT  = 3'd4
	} action_t;

	localparam logic [7:0] CMD_HOME   = 8'h80;
	localparam logic [7:0] CHAR_ERROR = 8'h45;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

	// Three wake-up nibbles, the switch to 4-bit mode, then 0x28 0x01 0x06 0x0E 0x80.
	localparam logic [3:0] INIT_NIB [INIT_STROBES] = '{
		4'h3, 4'h3, 4'h3, 4'h2,
		4'h2, 4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hE, 4'h8, 4'h0
	};

	typedef struct packed {
		logic                        init;
		logic                        pfx;
		logic [7:0]                  pfx_byte;
		logic                        body_rs;
		logic [2:0]                  nbytes;
		logic [DIGIT_CAP-1:0][7:0]   body;
	} job_t;

endpackage

`default_nettype wire

@@ rtl/clnib_front.sv @@
// Front end: accepts requests, classifies them and builds a strobe job.
// Decimal digits are extracted one per cycle. Depends on clnib_pkg.
`default_nettype none

module clnib_front
	import clnib_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  byte_value,
	input  wire logic [2:0]  row,
	input  wire logic [5:0]  column,
	input  wire logic [15:0] number,
	input  wire logic [2:0]  digit_count,
	output logic             push,
	output job_t             push_job,
	input  wire logic        queue_full
);

	typedef enum logic {
		S_IDLE,
		S_DIGITS
	} state_t;

	state_t     state_q;
	logic       job_valid_q;
	job_t       job_q;
	logic [15:0] v_q;
	logic [2:0]  k_q;

	logic        accept;
	logic        row_ok;
	logic [7:0]  cursor_cmd;
	logic        too_many;
	logic [2:0]  k_cap;
	logic [32:0] prod;
	logic [12:0] quot;
	logic [15:0] rem;
	job_t        job_new;
	logic        job_nonempty;

	assign req_stall = (state_q != S_IDLE) || job_valid_q;
	assign accept    = req_valid && !req_stall;
	assign push      = job_valid_q && !queue_full;
	assign push_job  = job_q;

	assign row_ok     = (row >= 3'd1) && (row <= 3'd4);
	assign cursor_cmd = ROW_BASE[2'(row - 3'd1)] + {2'b00, column} - 8'd1;
	assign too_many   = int'(digit_count) > MAX_DIGITS;
	assign k_cap      = (int'(digit_count) > DIGIT_CAP) ? 3'(DIGIT_CAP) : digit_count;

	// Divide by ten as a multiply by the reciprocal; exact over 16 bits.
	assign prod = {17'd0, v_q} * 33'd52429;
	assign quot = prod[31:19];
	assign rem  = v_q - ({3'b000, quot} * 16'd10);

	always_comb begin
		job_new      = '0;
		job_nonempty = 1'b0;
		case (action)
			ACT_INIT: begin
				job_new.init = 1'b1;
				job_nonempty = 1'b1;
			end
			ACT_CMD, ACT_DATA: begin
				job_new.body_rs = (action == ACT_DATA);
				job_new.nbytes  = 3'd1;
				job_new.body[0] = byte_value;
				job_nonempty    = 1'b1;
			end
			ACT_CURSOR: begin
				job_new.pfx      = row_ok;
				job_new.pfx_byte = cursor_cmd;
				job_nonempty     = row_ok;
			end
			ACT_PRINT: begin
				job_new.body_rs = 1'b1;
				if (row == 3'd0 || column == 6'd0) begin
					job_new.pfx      = 1'b1;
					job_new.pfx_byte = CMD_HOME;
				end else begin
					job_new.pfx      = row_ok;
					job_new.pfx_byte = cursor_cmd;
				end
				if (too_many) begin
					job_new.nbytes  = 3'd1;
					job_new.body[0] = CHAR_ERROR;
				end else begin
					job_new.nbytes = k_cap;
				end
				job_nonempty = job_new.pfx || (job_new.nbytes != 3'd0);
			end
			default: begin
				job_nonempty = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_valid_q <= 1'b0;
		end else begin
			if (push)
				job_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						job_q <= job_new;
						v_q   <= number;
						k_q   <= k_cap - 3'd1;
						if (action == ACT_PRINT && !too_many && k_cap != 3'd0)
							state_q <= S_DIGITS;
						else
							job_valid_q <= job_nonempty;
					end
				end
				S_DIGITS: begin
					// Digits come out least significant first, filled from the far end.
					job_q.body[k_q] <= CHAR_ZERO + {4'h0, rem[3:0]};
					v_q             <= {3'b000, quot};
					k_q             <= k_q - 3'd1;
					if (k_q == 3'd0) begin
						job_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/clnib_queue.sv @@
// Short job queue between front and back end, held in registers.
// Depends on clnib_pkg for the job type.
`default_nettype none

module clnib_queue
	import clnib_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head_job,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/clnib_back.sv @@
// Back end: steps through a job and emits one nibble strobe per cycle while the output is not
// stalled, into a registered output word. Depends on clnib_pkg.
`default_nettype none

module clnib_back
	import clnib_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      head_job,
	input  wire logic queue_empty,
	output logic      pop,
	output logic      strobe_valid,
	input  wire logic strobe_stall,
	output logic      reg_select,
	output logic [3:0] nibble,
	output logic      last
);

	logic       active_q;
	job_t       job_q;
	logic [3:0] step_q;
	logic [3:0] total_q;

	logic       advance;
	logic [3:0] j;
	logic [2:0] bidx;
	logic [7:0] cur_byte;
	logic       cur_rs;
	logic [3:0] cur_nib;
	logic [3:0] head_total;
	logic       is_last;

	assign pop     = !active_q && !queue_empty;
	assign advance = active_q && (!strobe_valid || !strobe_stall);
	assign is_last = (step_q == total_q - 4'd1);

	assign head_total = head_job.init ? 4'(INIT_STROBES)
		: ({3'b000, head_job.pfx} << 1) + {head_job.nbytes, 1'b0};

	always_comb begin
		j        = step_q - (job_q.pfx ? 4'd2 : 4'd0);
		bidx     = j[3:1];
		cur_byte = 8'h00;
		cur_rs   = 1'b0;
		if (job_q.pfx && step_q < 4'd2) begin
			cur_byte = job_q.pfx_byte;
			j        = step_q;
		end else if (int'(bidx) < DIGIT_CAP) begin
			cur_byte = job_q.body[bidx];
			cur_rs   = job_q.body_rs;
		end
		// A byte goes out high nibble first.
		cur_nib = j[0] ? cur_byte[3:0] : cur_byte[7:4];
		if (job_q.init) begin
			cur_rs  = 1'b0;
			cur_nib = (int'(step_q) < INIT_STROBES) ? INIT_NIB[step_q] : 4'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			strobe_valid <= 1'b0;
		end else begin
			if (advance)
				strobe_valid <= 1'b1;
			else if (strobe_valid && !strobe_stall)
				strobe_valid <= 1'b0;
			if (pop) begin
				active_q <= 1'b1;
				job_q    <= head_job;
				step_q   <= '0;
				total_q  <= head_total;
			end else if (advance) begin
				reg_select   <= cur_rs;
				nibble       <= cur_nib;
				last         <= is_last;
				step_q       <= step_q + 4'd1;
				if (is_last)
					active_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_interface.sv @@
// Character LCD 4-bit interface: requests in, register-select tagged nibble strobes out.
// The front end turns each accepted request into a job, extracting print digits one per cycle;
// the queue passes jobs on to the back end, which loads each job before its first strobe.
// Throughput: the back end emits one strobe per cycle unless the receiver stalls, up to 14 per
// request; the front end takes no new request until its job is pushed, so the back end sets it.
// Reset: asynchronous active-low arst_n empties the queue and idles both ends.
`default_nettype none

module char_lcd_nibble_interface
	import clnib_pkg::*;
#(
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  byte_value,
	input  wire logic [2:0]  row,
	input  wire logic [5:0]  column,
	input  wire logic [15:0] number,
	input  wire logic [2:0]  digit_count,
	output logic             strobe_valid,
	input  wire logic        strobe_stall,
	output logic             reg_select,
	output logic [3:0]       nibble,
	output logic             last
);

	logic push;
	job_t push_job;
	logic queue_full;
	logic pop;
	job_t head_job;
	logic queue_empty;

	clnib_front #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.byte_value  (byte_value),
		.row         (row),
		.column      (column),
		.number      (number),
		.digit_count (digit_count),
		.push        (push),
		.push_job    (push_job),
		.queue_full  (queue_full)
	);

	clnib_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (queue_empty)
	);

	clnib_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.queue_empty  (queue_empty),
		.pop          (pop),
		.strobe_valid (strobe_valid),
		.strobe_stall (strobe_stall),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.last         (last)
	);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for char_lcd_nibble_interface: random and directed request words,
// a scoreboard class that predicts the nibble strobe words, and random stalls on both sides.
// Depends on rtl/clnib_pkg.sv and rtl/char_lcd_nibble_interface.sv.
`timescale 1ns / 100ps

module testbench;
	import clnib_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LIMIT = 100;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;

	// Action codes the block ignores.
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam logic       RS_CMD   = 1'b0;
	localparam logic       RS_DATA  = 1'b1;
	localparam logic [3:0] WAKE_NIB = 4'h3;
	localparam logic [3:0] MODE_NIB = 4'h2;
	localparam logic [7:0] SETUP_CMDS [5] = '{8'h28, 8'h01, 8'h06, 8'h0E, 8'h80};

	typedef struct {
		logic [2:0]  action;
		logic [7:0]  byte_value;
		logic [2:0]  row;
		logic [5:0]  column;
		logic [15:0] number;
		logic [2:0]  digit_count;
	} request_t;

	typedef struct {
		logic       rs;
		logic [3:0] nib;
		logic       last;
	} strobe_t;

	class lcd_scoreboard;
		strobe_t pending[$];
		int      errors;
		int      requests;
		int      strobes;

		function void push_strobe(logic rs, logic [3:0] nib);
			strobe_t s;
			s.rs   = rs;
			s.nib  = nib;
			s.last = 1'b0;
			pending.push_back(s);
		endfunction

		function void push_byte(logic rs, logic [7:0] b);
			push_strobe(rs, b[7:4]);
			push_strobe(rs, b[3:0]);
		endfunction

		// Rows outside one to four give no cursor command at all.
		function void push_cursor(logic [2:0] r, logic [5:0] c);
			logic [7:0] cmd;
			if (r >= 3'd1 && r <= 3'd4) begin
				cmd = ROW_BASE[r - 3'd1] + {2'b00, c} - 8'd1;
				push_byte(RS_CMD, cmd);
			end
		endfunction

		function int note_request(request_t r);
			int          first;
			int          k;
			int unsigned v;
			logic [7:0]  digs [DIGIT_CAP];
			first = pending.size();
			requests++;
			case (r.action)
				ACT_INIT: begin
					repeat (3) push_strobe(RS_CMD, WAKE_NIB);
					push_strobe(RS_CMD, MODE_NIB);
					foreach (SETUP_CMDS[i]) push_byte(RS_CMD, SETUP_CMDS[i]);
				end
				ACT_CMD: push_byte(RS_CMD, r.byte_value);
				ACT_DATA: push_byte(RS_DATA, r.byte_value);
				ACT_CURSOR: push_cursor(r.row, r.column);
				ACT_PRINT: begin
					if (r.row == 3'd0 || r.column == 6'd0)
						push_byte(RS_CMD, CMD_HOME);
					else
						push_cursor(r.row, r.column);
					if (int'(r.digit_count) > MAX_DIGITS_DEF) begin
						push_byte(RS_DATA, CHAR_ERROR);
					end else begin
						k = int'(r.digit_count);
						if (k > DIGIT_CAP)
							k = DIGIT_CAP;
						v = r.number;
						for (int i = k - 1; i >= 0; i--) begin
							digs[i] = 8'(v % 10);
							v = v / 10;
						end
						for (int i = 0; i < k; i++)
							push_byte(RS_DATA, CHAR_ZERO + digs[i]);
					end
				end
				default: ;
			endcase
			if (pending.size() > first)
				pending[pending.size() - 1].last = 1'b1;
			return pending.size() - first;
		endfunction

		function void check_strobe(logic rs, logic [3:0] nib, logic lst);
			strobe_t e;
			strobes++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: strobe word with nothing expected: rs %b nibble %h last %b",
						$time, rs, nib, lst);
				return;
			end
			e = pending.pop_front();
			if (rs !== e.rs || nib !== e.nib || lst !== e.last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"%0t: strobe mismatch: expected rs %b nibble %h last %b, ",
						"got rs %b nibble %h last %b"},
						$time, e.rs, e.nib, e.last, rs, nib, lst);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  action;
	logic [7:0]  byte_value;
	logic [2:0]  row;
	logic [5:0]  column;
	logic [15:0] number;
	logic [2:0]  digit_count;
	logic        strobe_valid;
	logic        strobe_stall;
	logic        reg_select;
	logic [3:0]  nibble;
	logic        last;

	lcd_scoreboard board = new();
	bit  send_idle;
	bit  recv_idle;
	int  long_hold_cycles;
	int  cycles;

	char_lcd_nibble_interface i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.byte_value   (byte_value),
		.row          (row),
		.column       (column),
		.number       (number),
		.digit_count  (digit_count),
		.strobe_valid (strobe_valid),
		.strobe_stall (strobe_stall),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d strobe words outstanding",
				$time, board.pending.size());
			$display("FAIL char_lcd_nibble_interface");
			$finish;
		end
	end

	// Receiving side: checks every accepted strobe word and stalls in random bursts.
	initial begin
		int  burst_left;
		int  hold_left;
		bit  hold_taken;
		bit  stall_next;
		burst_left   = 0;
		hold_left    = 0;
		hold_taken   = 1'b0;
		strobe_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && strobe_valid && !strobe_stall)
				board.check_strobe(reg_select, nibble, last);
			@(negedge clk);
			if (!hold_taken && long_hold_cycles > 0) begin
				hold_taken = 1'b1;
				hold_left  = long_hold_cycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				stall_next = 1'b1;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 11) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			strobe_stall <= stall_next;
		end
	end

	function automatic request_t make_request(logic [2:0] act, logic [7:0] bval, logic [2:0] r,
		logic [5:0] c, logic [15:0] num, logic [2:0] cnt);
		request_t q;
		q.action      = act;
		q.byte_value  = bval;
		q.row         = r;
		q.column      = c;
		q.number      = num;
		q.digit_count = cnt;
		return q;
	endfunction

	// Mostly print and cursor words with random content, some spare codes as noise.
	function automatic request_t random_request();
		request_t q;
		int       pick;
		q    = make_request(ACT_INIT, 8'($urandom), 3'($urandom), 6'($urandom), 16'($urandom),
			3'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 4)
			q.action = ACT_INIT;
		else if (pick < 19)
			q.action = ACT_CMD;
		else if (pick < 39)
			q.action = ACT_DATA;
		else if (pick < 57)
			q.action = ACT_CURSOR;
		else if (pick < 95)
			q.action = ACT_PRINT;
		else
			q.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		return q;
	endfunction

	// Starts on a falling edge and returns on the falling edge after acceptance.
	task automatic send_request(input request_t r, output int produced);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		action      <= r.action;
		byte_value  <= r.byte_value;
		row         <= r.row;
		column      <= r.column;
		number      <= r.number;
		digit_count <= r.digit_count;
		req_valid   <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		produced = board.note_request(r);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	task automatic send_random(input int target);
		int got;
		int n;
		got = 0;
		while (got < target) begin
			send_request(random_request(), n);
			if (n > 0)
				got++;
		end
	endtask

	initial begin
		request_t directed[$];
		int       n;
		arst_n           = 1'b0;
		req_valid        = 1'b0;
		action           = ACT_INIT;
		byte_value       = '0;
		row              = '0;
		column           = '0;
		number           = '0;
		digit_count      = '0;
		send_idle        = 1'b1;
		recv_idle        = 1'b1;
		long_hold_cycles = 0;
		cycles           = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed.push_back(make_request(ACT_INIT,   8'h00, 3'd0, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CMD,    8'h00, 3'd0, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CMD,    8'hFF, 3'd7, 6'd63, 16'hFFFF,  3'd7));
		directed.push_back(make_request(ACT_DATA,   8'h00, 3'd0, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_DATA,   8'hFF, 3'd0, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd1, 6'd1,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd4, 6'd63, 16'd0,     3'd0));
		// Column zero wraps below the row base.
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd1, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd2, 6'd0,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd3, 6'd20, 16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd0, 6'd5,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd5, 6'd5,  16'd0,     3'd0));
		directed.push_back(make_request(ACT_CURSOR, 8'h00, 3'd7, 6'd63, 16'd0,     3'd0));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd0, 6'd5,  16'hFFFF,  3'd5));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd2, 6'd0,  16'd12345, 3'd3));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd3, 6'd10, 16'd99,    3'd0));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd4, 6'd63, 16'd7,     3'd6));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd1, 6'd1,  16'd0,     3'd7));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd6, 6'd3,  16'd54321, 3'd3));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd1, 6'd2,  16'd0,     3'd1));
		directed.push_back(make_request(ACT_PRINT,  8'h00, 3'd4, 6'd20, 16'd40960, 3'd5));
		for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
			directed.push_back(make_request(3'(a), 8'hFF, 3'd1, 6'd1, 16'hFFFF, 3'd5));
		foreach (directed[i])
			send_request(directed[i], n);

		send_random(60);
		req_valid <= 1'b0;

		// Hold the receiver off while the sender keeps offering, so the block backs up.
		wait_for_results();
		send_idle        = 1'b0;
		long_hold_cycles = LONG_HOLD;
		for (int i = 0; i < 14; i++)
			send_request(make_request(i % 3 == 0 ? ACT_INIT : ACT_PRINT, 8'($urandom), 3'($urandom),
				6'($urandom), 16'($urandom), 3'($urandom_range(0, 5))), n);
		req_valid <= 1'b0;

		// The sender pauses until every strobe word of the backlog has arrived.
		wait_for_results();
		send_idle = 1'b1;
		send_random(20);

		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_random(25);
		req_valid <= 1'b0;

		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Run covered %0d request words and %0d strobe words, with long back-pressure",
			board.requests, board.strobes);
		$display("and random gaps on both sides; %0d mismatches, %0d strobe words outstanding.",
			board.errors, board.pending.size());
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS char_lcd_nibble_interface");
		else
			$display("FAIL char_lcd_nibble_interface");
		$finish;
	end

endmodule
